// File: src/pdcl_pkg.sv
`default_nettype none

package pdcl_pkg;

	// Dial sequencer phases, coded as the result field reports them
	typedef enum logic [2:0] {
		PH_HALT  = 3'd0,
		PH_RISE  = 3'd1,
		PH_COUNT = 3'd2,
		PH_FALL  = 3'd3,
		PH_CHECK = 3'd4,
		PH_OPEN  = 3'd5
	} phase_t;

	localparam int CODE_W      = 20;
	localparam int TICKS_W     = 16;
	localparam int COUNT_W     = 8;
	localparam int IDX_W       = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = CODE_W;
	localparam int DEF_CODE_LEN = 5;

	localparam logic [CODE_W-1:0]  DEF_CODE_WORD  = 20'h30954;
	localparam logic [TICKS_W-1:0] DEF_OPEN_TICKS = 16'd12000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_WORD  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS = 1'b1;

	typedef struct packed {
		phase_t              phase;
		logic [COUNT_W-1:0]  pulse_count;
		logic [IDX_W-1:0]    digit_index;
		logic [TICKS_W-1:0]  open_countdown;
		logic                relay;
		logic                indicator;
	} lock_state_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code_word;
		logic [TICKS_W-1:0] open_ticks;
	} lock_cfg_t;

	// Dialed digit: (count - 1) mod 10, by reciprocal multiply (exact over the whole 8-bit count range)
	function automatic logic [3:0] dialed_digit(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] x;
		logic [15:0]        prod;
		logic [4:0]         quot;
		logic [COUNT_W-1:0] rem;
		x    = count - COUNT_W'(1);
		prod = 16'(x) * 16'd205;
		quot = prod[15:11];
		rem  = x - COUNT_W'(quot) * COUNT_W'(10);
		return rem[3:0];
	endfunction

endpackage

`default_nettype wire

// File: src/pulse_dial_code_lock_top.sv
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_ready  | dial_line, pulse_line, polarity_line
// result    | out_valid / out_ready| relay_out, indicator_out, phase
// config    | cfg_we               | cfg_index, cfg_data (no wait, no read-back)
//
// One sampling tick per clock sustained while the result side does not stall.
// Each beat waits in the input register until the result slot can take its result.
// The lock state registers double as the result register; they advance only
// when the result slot is free or being taken, so a stall on the result side
// holds one beat in the input register and then drops in_ready.
// Reset is asynchronous, active low, and loads the default code and open time.

module pulse_dial_code_lock_top #(
	parameter int CODE_LEN = pdcl_pkg::DEF_CODE_LEN
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            dial_line,
	input  wire logic                            pulse_line,
	input  wire logic                            polarity_line,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 relay_out,
	output logic                                 indicator_out,
	output logic [2:0]                           phase,
	input  wire logic                            cfg_we,
	input  wire logic [pdcl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pdcl_pkg::CFG_DATA_W-1:0] cfg_data
);

	pdcl_pkg::lock_cfg_t   cfg;
	pdcl_pkg::lock_state_t state_q;
	pdcl_pkg::lock_state_t state_nxt;

	logic valid_s1;
	logic dial_s1;
	logic pulse_s1;
	logic polarity_s1;
	logic out_valid_q;
	logic advance;

	pdcl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdcl_next #(
		.CODE_LEN (CODE_LEN)
	) u_next (
		.cur      (state_q),
		.cfg      (cfg),
		.dial     (dial_s1),
		.pulse    (pulse_s1),
		.polarity (polarity_s1),
		.nxt      (state_nxt)
	);

	// Result slot frees when empty or when its beat is taken this cycle
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Input register: capture a beat whenever the stage can take one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			dial_s1     <= dial_line;
			pulse_s1    <= pulse_line;
			polarity_s1 <= polarity_line;
		end
	end

	// Lock state, also the registered result of the last tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase          <= pdcl_pkg::PH_RISE;
			state_q.pulse_count    <= '0;
			state_q.digit_index    <= '0;
			state_q.open_countdown <= pdcl_pkg::DEF_OPEN_TICKS;
			state_q.relay          <= 1'b0;
			state_q.indicator      <= 1'b0;
			out_valid_q            <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign relay_out     = state_q.relay;
	assign indicator_out = state_q.indicator;
	assign phase         = state_q.phase;

	// Halted is final until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == pdcl_pkg::PH_HALT |=> state_q.phase == pdcl_pkg::PH_HALT)
		else $error("lock left the halted phase");

	// Indicator only lights during or right after the open phase
	a_ind_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.indicator |->
		(state_q.phase == pdcl_pkg::PH_OPEN || state_q.phase == pdcl_pkg::PH_HALT))
		else $error("indicator set outside open phase");

	// Count is cleared once the last digit matched
	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == pdcl_pkg::PH_OPEN |-> state_q.pulse_count == '0)
		else $error("pulse count not cleared on open");

	// A held input beat does not move the lock state
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> ($stable(state_q) && valid_s1))
		else $error("state moved while result stalled");

endmodule

`default_nettype wire

// File: src/pdcl_cfg.sv
`default_nettype none

module pdcl_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pdcl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pdcl_pkg::CFG_DATA_W-1:0]   cfg_data,
	output pdcl_pkg::lock_cfg_t                    cfg
);

	pdcl_pkg::lock_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_word  <= pdcl_pkg::DEF_CODE_WORD;
			cfg_q.open_ticks <= pdcl_pkg::DEF_OPEN_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				pdcl_pkg::CFG_CODE_WORD:  cfg_q.code_word  <= cfg_data;
				pdcl_pkg::CFG_OPEN_TICKS: cfg_q.open_ticks <= cfg_data[pdcl_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: src/pdcl_next.sv
`default_nettype none

module pdcl_next #(
	parameter int CODE_LEN = pdcl_pkg::DEF_CODE_LEN
) (
	input  wire pdcl_pkg::lock_state_t cur,
	input  wire pdcl_pkg::lock_cfg_t   cfg,
	input  wire logic                  dial,
	input  wire logic                  pulse,
	input  wire logic                  polarity,
	output pdcl_pkg::lock_state_t      nxt
);

	localparam logic [pdcl_pkg::IDX_W-1:0] LAST_IDX = pdcl_pkg::IDX_W'(CODE_LEN - 1);

	logic [pdcl_pkg::IDX_W-1:0] shift;
	logic [31:0]                code_ext;
	logic [31:0]                code_sh;
	logic [3:0]                 want;
	logic [3:0]                 got;

	// Code nibble for the current digit; first digit sits in the top used nibble
	assign shift    = LAST_IDX - cur.digit_index;
	assign code_ext = 32'(cfg.code_word);
	assign code_sh  = code_ext >> {shift, 2'b00};
	assign want     = code_sh[3:0];
	assign got      = pdcl_pkg::dialed_digit(cur.pulse_count);

	always_comb begin
		nxt = cur;
		case (cur.phase)
			pdcl_pkg::PH_RISE: begin
				if (!dial) begin
					nxt.phase = pdcl_pkg::PH_CHECK;
				end else if (pulse) begin
					nxt.phase = pdcl_pkg::PH_COUNT;
				end
			end
			pdcl_pkg::PH_COUNT: begin
				nxt.pulse_count = cur.pulse_count + pdcl_pkg::COUNT_W'(1);
				nxt.phase       = pdcl_pkg::PH_FALL;
			end
			pdcl_pkg::PH_FALL: begin
				if (!dial) begin
					nxt.phase = pdcl_pkg::PH_CHECK;
				end else if (!pulse) begin
					nxt.phase = pdcl_pkg::PH_RISE;
				end
			end
			pdcl_pkg::PH_CHECK: begin
				if (cur.pulse_count <= pdcl_pkg::COUNT_W'(1)) begin
					nxt.phase = pdcl_pkg::PH_RISE;
				end else if (got != want) begin
					nxt.phase = pdcl_pkg::PH_HALT;
				end else begin
					nxt.pulse_count = '0;
					nxt.digit_index = cur.digit_index + pdcl_pkg::IDX_W'(1);
					if (cur.digit_index == LAST_IDX) begin
						nxt.open_countdown = cfg.open_ticks;
						nxt.phase          = pdcl_pkg::PH_OPEN;
					end else begin
						nxt.phase = pdcl_pkg::PH_RISE;
					end
				end
			end
			pdcl_pkg::PH_OPEN: begin
				if (cur.open_countdown != '0) begin
					nxt.indicator      = 1'b1;
					nxt.relay          = polarity;
					nxt.open_countdown = cur.open_countdown - pdcl_pkg::TICKS_W'(1);
				end else begin
					nxt.phase = pdcl_pkg::PH_HALT;
				end
			end
			default: begin
				// Halted: drop the relay (inverted drive when polarity is low)
				nxt.phase     = pdcl_pkg::PH_HALT;
				nxt.indicator = 1'b0;
				nxt.relay     = !polarity;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import pdcl_pkg::*;

	localparam int CODE_LEN   = DEF_CODE_LEN;
	localparam int LIVE_TICKS = 110;

	// Levels the block reports after each tick
	typedef struct packed {
		logic       relay;
		logic       indicator;
		logic [2:0] phase;
	} lock_levels_t;

	// How the final code attempt ends: the lock can only halt once per run
	typedef enum int {
		END_OPEN,
		END_WRONG,
		END_BAD_NIBBLE
	} ending_t;

	// Tracks the lock state tick by tick and holds the levels still due
	class lock_tracker;
		lock_state_t  st;
		lock_cfg_t    cfg;
		lock_levels_t due[$];
		int           errors;

		function new();
			cfg.code_word     = DEF_CODE_WORD;
			cfg.open_ticks    = DEF_OPEN_TICKS;
			st.phase          = PH_RISE;
			st.pulse_count    = '0;
			st.digit_index    = '0;
			st.open_countdown = DEF_OPEN_TICKS;
			st.relay          = 1'b0;
			st.indicator      = 1'b0;
			errors            = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == CFG_CODE_WORD) begin
				cfg.code_word = data;
			end else begin
				cfg.open_ticks = data[TICKS_W-1:0];
			end
		endfunction

		function logic [3:0] code_nibble(logic [IDX_W-1:0] idx);
			int sh;
			sh = (CODE_LEN - 1 - int'(idx)) & 7;
			return 4'(cfg.code_word >> (4 * sh));
		endfunction

		function void note_tick(bit dial, bit pulse, bit pol);
			lock_levels_t lv;
			bit           is_last;
			case (st.phase)
				PH_RISE: begin
					if (!dial) st.phase = PH_CHECK;
					else if (pulse) st.phase = PH_COUNT;
				end
				PH_COUNT: begin
					st.pulse_count = st.pulse_count + 1'b1;
					st.phase       = PH_FALL;
				end
				PH_FALL: begin
					if (!dial) st.phase = PH_CHECK;
					else if (!pulse) st.phase = PH_RISE;
				end
				PH_CHECK: begin
					if (st.pulse_count <= 1) begin
						st.phase = PH_RISE;
					end else if ((int'(st.pulse_count) - 1) % 10 != code_nibble(st.digit_index)) begin
						st.phase = PH_HALT;
					end else begin
						is_last        = (st.digit_index == CODE_LEN - 1);
						st.pulse_count = '0;
						st.digit_index = st.digit_index + 1'b1;
						if (is_last) begin
							st.open_countdown = cfg.open_ticks;
							st.phase          = PH_OPEN;
						end else begin
							st.phase = PH_RISE;
						end
					end
				end
				PH_OPEN: begin
					if (st.open_countdown != 0) begin
						st.indicator      = 1'b1;
						st.relay          = pol;
						st.open_countdown = st.open_countdown - 1'b1;
					end else begin
						st.phase = PH_HALT;
					end
				end
				default: begin
					st.phase     = PH_HALT;
					st.indicator = 1'b0;
					st.relay     = !pol;
				end
			endcase
			lv.relay     = st.relay;
			lv.indicator = st.indicator;
			lv.phase     = st.phase;
			due.push_back(lv);
		endfunction

		function void check_result(logic relay, logic indicator, logic [2:0] ph);
			lock_levels_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: result beat with no tick outstanding (relay %0d indicator %0d phase %0d)",
					$time, relay, indicator, ph);
				return;
			end
			want = due.pop_front();
			if (relay !== want.relay) begin
				errors++;
				$display("%0t: relay_out expected %0d, got %0d", $time, want.relay, relay);
			end
			if (indicator !== want.indicator) begin
				errors++;
				$display("%0t: indicator_out expected %0d, got %0d", $time, want.indicator, indicator);
			end
			if (ph !== want.phase) begin
				errors++;
				$display("%0t: phase expected %0d, got %0d", $time, want.phase, ph);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	logic                  dial_line     = 1'b1;
	logic                  pulse_line    = 1'b0;
	logic                  polarity_line = 1'b1;
	logic                  out_ready     = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = CFG_CODE_WORD;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	wire                   in_ready;
	wire                   out_valid;
	wire                   relay_out;
	wire                   indicator_out;
	wire [2:0]             phase;

	lock_tracker sb = new();

	// Percent chance per cycle of a sender gap or a receiver stall, set per phase
	int idle_in_pct = 0;
	int stall_pct   = 0;
	int idle_tbl[4]  = '{0, 46, 0, 30};
	int stall_tbl[4] = '{0, 0, 46, 30};
	int items_sent   = 0;

	pulse_dial_code_lock_top #(
		.CODE_LEN(CODE_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dial_line(dial_line),
		.pulse_line(pulse_line),
		.polarity_line(polarity_line),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.relay_out(relay_out),
		.indicator_out(indicator_out),
		.phase(phase),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("FAIL pulse_dial_code_lock_top");
		$finish;
	end

	// Receiver side: stall at the rate of the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare every result beat taken at this edge against the oldest tick due
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(relay_out, indicator_out, phase);
		end
	end

	function automatic bit coin();
		return bit'($urandom_range(1));
	endfunction

	// Code word made of decimal digits only, so every position can be matched
	function automatic logic [CODE_W-1:0] digits_code();
		logic [CODE_W-1:0] code;
		int                i;
		code = '0;
		for (i = 0; i < CODE_LEN; i++) begin
			code[4*i +: 4] = 4'($urandom_range(9));
		end
		return code;
	endfunction

	// Offer one tick; hold valid and payload until the beat is taken, then
	// advance the tracker at that same edge.
	task automatic send_tick(input bit d, input bit p, input bit q);
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		dial_line     <= d;
		pulse_line    <= p;
		polarity_line <= q;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_tick(d, p, q);
		items_sent++;
	endtask

	// Drop valid and wait until every result due has been taken
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
	endtask

	// Write both registers on back-to-back edges while the lock is idle
	task automatic write_cfg(input logic [CODE_W-1:0] code, input logic [TICKS_W-1:0] ticks);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CODE_WORD;
		cfg_data  <= code;
		@(posedge clk);
		sb.write_reg(CFG_CODE_WORD, code);
		cfg_index <= CFG_OPEN_TICKS;
		cfg_data  <= CFG_DATA_W'(ticks);
		@(posedge clk);
		sb.write_reg(CFG_OPEN_TICKS, CFG_DATA_W'(ticks));
		cfg_we    <= 1'b0;
	endtask

	// Dial one digit as a pulse train with random contact bounce, then close it.
	// A negative digit dials a train short enough to be ignored (total count
	// of 0 or 1); otherwise the count lands on the digit, wrapping by up to
	// max_wrap extra tens.
	task automatic dial_burst(input int digit, input int max_wrap);
		int target;
		int n;
		int i;
		// Bring the dial back to waiting for a rising pulse
		while (sb.st.phase != PH_RISE) send_tick(1'b1, 1'b0, coin());
		if (digit < 0) begin
			n = (sb.st.pulse_count == 0) ? $urandom_range(1) : 0;
		end else begin
			target = digit + 1;
			if (target < 2) target = 11;
			target += 10 * $urandom_range(max_wrap);
			n = target - int'(sb.st.pulse_count);
		end
		for (i = 0; i < n; i++) begin
			send_tick(1'b1, 1'b1, coin());
			send_tick(1'b1, coin(), coin());
			while ($urandom_range(3) == 0) send_tick(1'b1, 1'b1, coin());
			// Sometimes close the digit while the pulse is still high
			if (i < n - 1 || coin()) begin
				send_tick(1'b1, 1'b0, coin());
				while ($urandom_range(3) == 0) send_tick(1'b1, 1'b0, coin());
			end
		end
		send_tick(1'b0, coin(), coin());
		send_tick(coin(), coin(), coin());
	endtask

	// Random contact noise that never builds a count of two or more, so no
	// stray digit gets checked
	task automatic stray_ticks(input int count);
		bit d;
		bit p;
		repeat (count) begin
			d = coin();
			p = coin();
			if (sb.st.phase == PH_RISE && sb.st.pulse_count != 0 && d) p = 1'b0;
			send_tick(d, p, coin());
		end
	endtask

	// Mostly whole digit trains, a few correct digits while positions remain
	// before the last one, the rest noise
	task automatic run_live(input int goal);
		int         last_item;
		int         dig;
		logic [3:0] nib;
		last_item = items_sent + goal;
		while (items_sent < last_item) begin
			if ($urandom_range(9) < 7) begin
				dig = -1;
				nib = sb.code_nibble(sb.st.digit_index);
				if (sb.st.digit_index < CODE_LEN - 1 && nib <= 9 && $urandom_range(7) == 0) begin
					dig = nib;
				end
				dial_burst(dig, 2);
			end else begin
				stray_ticks($urandom_range(6, 1));
			end
		end
	endtask

	initial begin
		ending_t           ending;
		logic [3:0]        nib;
		logic [CODE_W-1:0] code;
		int                ph;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: dial low with no pulses, a lone pulse that is kept,
		// then enough pulses on top of it to match the first default digit
		send_tick(1'b0, 1'b0, 1'b0);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b0);
		dial_burst(sb.code_nibble(sb.st.digit_index), 0);

		// Live phases: all-illegal code with the longest open time, all-zero
		// code with no open time, then random settings
		for (ph = 0; ph < 4; ph++) begin
			drain();
			idle_in_pct = idle_tbl[ph];
			stall_pct   = stall_tbl[ph];
			case (ph)
				0: write_cfg('1, '1);
				1: write_cfg('0, '0);
				2: write_cfg(digits_code(), TICKS_W'($urandom));
				default: write_cfg(CODE_W'($urandom), TICKS_W'($urandom));
			endcase
			run_live(LIVE_TICKS);
		end

		// Finish the code: open the lock, or fail on the last digit through a
		// wrong count or a code position above nine
		drain();
		ending = ($urandom_range(3) < 2) ? END_OPEN : ending_t'($urandom_range(2, 1));
		code   = digits_code();
		if (ending == END_BAD_NIBBLE) code[3:0] = 4'($urandom_range(15, 10));
		write_cfg(code, TICKS_W'($urandom_range(40)));
		while (sb.st.digit_index < CODE_LEN - 1) begin
			dial_burst(sb.code_nibble(sb.st.digit_index), 1);
		end
		nib = sb.code_nibble(sb.st.digit_index);
		case (ending)
			END_OPEN: dial_burst(nib, 1);
			END_WRONG: dial_burst((nib + $urandom_range(9, 1)) % 10, 1);
			default: dial_burst($urandom_range(9), 1);
		endcase
		// Ride out the open time, then toggle polarity in the halted state
		while (sb.st.phase != PH_HALT) send_tick(coin(), coin(), coin());
		repeat (30) send_tick(coin(), coin(), coin());

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("PASS pulse_dial_code_lock_top");
		end else begin
			$display("FAIL pulse_dial_code_lock_top");
		end
		$finish;
	end

endmodule

// File: sim.f
src/pdcl_pkg.sv
src/pdcl_cfg.sv
src/pdcl_next.sv
src/pulse_dial_code_lock_top.sv
test/testbench.sv
